// ----- design/tfd_pkg.sv -----
// Shared package for the target follow decision block.
// Register map, mode codes, microcode format and the control program.
// No dependencies.
package tfd_pkg;

	localparam int WINDOW_DEPTH_DEF = 7;
	localparam int COORD_WIDTH_DEF  = 16;

	localparam int CFG_W   = 15;
	localparam int WAIT_W  = 8;
	localparam int IDX_W   = 3;
	localparam int SPEED_W = 16;
	localparam int MODE_W  = 2;

	localparam logic [IDX_W-1:0] REG_FOLLOW_DIST = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DEPTH_LIMIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_LOST_WAIT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FWD_SPEED   = 3'd4;
	localparam logic [IDX_W-1:0] REG_TURN_RATE   = 3'd5;

	localparam logic [CFG_W-1:0]  RST_FOLLOW_DIST = 15'd256;
	localparam logic [CFG_W-1:0]  RST_DEAD_BAND   = 15'd77;
	localparam logic [CFG_W-1:0]  RST_DEPTH_LIMIT = 15'd1792;
	localparam logic [WAIT_W-1:0] RST_LOST_WAIT   = 8'd10;
	localparam logic [CFG_W-1:0]  RST_FWD_SPEED   = 15'd115;
	localparam logic [CFG_W-1:0]  RST_TURN_RATE   = 15'd38;

	typedef enum logic [MODE_W-1:0] {
		MODE_DRIVE       = 2'd0,
		MODE_NAV_BLOCKED = 2'd1,
		MODE_NAV_LOST    = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_UPDATE,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_NUMER,
		OP_DIVIDE,
		OP_MEAN,
		OP_DECIDE
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_EMPTY,
		C_SCAN_MORE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT   = 4'd0;
	localparam step_t STEP_UPDATE = 4'd1;
	localparam step_t STEP_INIT   = 4'd2;
	localparam step_t STEP_SCAN   = 4'd3;
	localparam step_t STEP_NUMER  = 4'd4;
	localparam step_t STEP_DIVIDE = 4'd5;
	localparam step_t STEP_MEAN   = 4'd6;
	localparam step_t STEP_HOLD   = 4'd7;
	localparam step_t STEP_DECIDE = 4'd8;

	// jump to target when cond holds, else fall through to the next step
	typedef struct packed {
		logic  ready;
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		unique case (s)
			STEP_WAIT:   c = '{1'b1, OP_LATCH,     C_NO_INPUT,  STEP_WAIT};
			STEP_UPDATE: c = '{1'b0, OP_UPDATE,    C_NEVER,     STEP_WAIT};
			STEP_INIT:   c = '{1'b0, OP_SCAN_INIT, C_EMPTY,     STEP_HOLD};
			STEP_SCAN:   c = '{1'b0, OP_SCAN,      C_SCAN_MORE, STEP_SCAN};
			STEP_NUMER:  c = '{1'b0, OP_NUMER,     C_NEVER,     STEP_WAIT};
			STEP_DIVIDE: c = '{1'b0, OP_DIVIDE,    C_DIV_MORE,  STEP_DIVIDE};
			STEP_MEAN:   c = '{1'b0, OP_MEAN,      C_NEVER,     STEP_WAIT};
			STEP_HOLD:   c = '{1'b0, OP_NOP,       C_OUT_BUSY,  STEP_HOLD};
			STEP_DECIDE: c = '{1'b0, OP_DECIDE,    C_ALWAYS,    STEP_WAIT};
			default:     c = '{1'b0, OP_NOP,       C_ALWAYS,    STEP_WAIT};
		endcase
		return c;
	endfunction

endpackage

// ----- design/tfd_if.sv -----
// Valid/ready channel interfaces for detection frames and decisions.
// Depends on tfd_pkg.
interface tfd_frame_if
	import tfd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          target_seen;
	logic                          target_reachable;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;

	modport source (output valid, target_seen, target_reachable, pos_x, pos_y, input ready);
	modport sink (input valid, target_seen, target_reachable, pos_x, pos_y, output ready);
endinterface

interface tfd_result_if
	import tfd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [MODE_W-1:0]             mode;
	logic signed [SPEED_W-1:0]     linear_speed;
	logic signed [SPEED_W-1:0]     angular_speed;
	logic signed [COORD_WIDTH-1:0] goal_x;
	logic signed [COORD_WIDTH-1:0] goal_y;

	modport source (output valid, mode, linear_speed, angular_speed, goal_x, goal_y,
		input ready);
	modport sink (input valid, mode, linear_speed, angular_speed, goal_x, goal_y,
		output ready);
endinterface

// ----- design/tfd_lane.sv -----
// One axis of the window datapath: sum and extremes scan, trimmed numerator,
// restoring divide one bit per cycle, signed mean. Depends on tfd_pkg.
module tfd_lane
	import tfd_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  op_t                                  op,
	input  logic signed [COORD_WIDTH-1:0]        entry,
	input  logic                                 trim,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0]    divisor,
	output logic signed [COORD_WIDTH-1:0]        mean
);

	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = COORD_WIDTH + CW;

	logic signed [SUM_W-1:0]       sum_q;
	logic signed [COORD_WIDTH-1:0] mx_q;
	logic signed [COORD_WIDTH-1:0] mn_q;
	logic                          neg_q;
	logic [SUM_W-1:0]              quo_q;
	logic [CW-1:0]                 rem_q;
	logic signed [COORD_WIDTH-1:0] mean_q;

	logic signed [SUM_W-1:0]       entry_e;
	logic signed [SUM_W-1:0]       mx_e;
	logic signed [SUM_W-1:0]       mn_e;
	logic signed [SUM_W-1:0]       num;
	logic signed [SUM_W-1:0]       num_neg;
	logic [SUM_W-1:0]              num_mag;
	logic [CW:0]                   r2;
	logic [CW:0]                   r_sub;
	logic                          fits;
	logic [COORD_WIDTH-1:0]        q_low;
	logic signed [COORD_WIDTH-1:0] mean_n;

	assign entry_e = SUM_W'(entry);
	assign mx_e    = SUM_W'(mx_q);
	assign mn_e    = SUM_W'(mn_q);
	assign num     = trim ? (sum_q - mx_e - mn_e) : sum_q;
	assign num_neg = -num;
	assign num_mag = num[SUM_W-1] ? num_neg : num;

	assign r2    = {rem_q, quo_q[SUM_W-1]};
	assign fits  = r2 >= {1'b0, divisor};
	assign r_sub = r2 - {1'b0, divisor};

	assign q_low  = quo_q[COORD_WIDTH-1:0];
	assign mean_n = neg_q ? -q_low : q_low;
	assign mean   = mean_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_SCAN_INIT: begin
				sum_q <= '0;
				mx_q  <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
				mn_q  <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
			OP_SCAN: begin
				sum_q <= sum_q + entry_e;
				if (entry > mx_q) begin
					mx_q <= entry;
				end
				if (entry < mn_q) begin
					mn_q <= entry;
				end
			end
			OP_NUMER: begin
				neg_q <= num[SUM_W-1];
				quo_q <= num_mag;
				rem_q <= '0;
			end
			OP_DIVIDE: begin
				rem_q <= fits ? r_sub[CW-1:0] : r2[CW-1:0];
				quo_q <= {quo_q[SUM_W-2:0], fits};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
		end else if (op == OP_MEAN) begin
			mean_q <= mean_n;
		end
	end

endmodule

// ----- design/target_follow_decision_top.sv -----
// Target follow decision: microcoded sequencer over a position window,
// trimmed mean per axis and mode/steering decision. Depends on tfd_pkg,
// tfd_if (channels) and tfd_lane.
//
//  channel   | dir | transfer when        | payload
//  frame     | in  | frame.valid & ready  | target_seen, target_reachable, pos_x, pos_y
//  result    | out | result.valid & ready | mode, linear/angular_speed, goal_x, goal_y
//  wr_*      | in  | wr_en                | wr_index, wr_data
//
// A frame occupies the sequencer through the window scan, one stored entry
// per cycle (up to 7 entries with defaults), the serial divider, the mean
// step and the decision step, before the next frame is taken.
// With an empty window the scan, divide and mean steps are skipped.
// The result register holds one decision; the next frame is taken while it
// waits, and the sequencer stalls before its decision step until it drains.
// Reset clears the window count, history, lost counter, means and held goal.
module target_follow_decision_top
	import tfd_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	tfd_frame_if.sink         frame,
	tfd_result_if.source      result
);

	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int IW    = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = COORD_WIDTH + CW;
	localparam int DCW   = $clog2(SUM_W);
	localparam int E_W   = (COORD_WIDTH > CFG_W ? COORD_WIDTH : CFG_W) + 2;

	// configuration
	logic [CFG_W-1:0]  fd_q, db_q, dl_q, fs_q, tr_q;
	logic [WAIT_W-1:0] lw_q;

	// sequencer
	step_t         step_q;
	ctrl_t         ctrl;
	logic          jump;
	logic [IW-1:0] ptr_q;
	logic [DCW-1:0] div_cnt_q;

	// frame and state
	logic                          fr_seen_q, fr_reach_q;
	logic signed [COORD_WIDTH-1:0] fr_x_q, fr_y_q;
	logic signed [COORD_WIDTH-1:0] wx_q [WINDOW_DEPTH];
	logic signed [COORD_WIDTH-1:0] wy_q [WINDOW_DEPTH];
	logic [CW-1:0]                 count_q;
	logic                          have_hist_q;
	logic [WAIT_W-1:0]             lost_q;
	logic signed [COORD_WIDTH-1:0] held_x_q, held_y_q;

	// result register
	logic                          out_valid_q;
	mode_t                         out_mode_q;
	logic signed [SPEED_W-1:0]     out_lin_q, out_ang_q;

	// datapath
	logic [CW-1:0]                 ptr_start;
	logic                          trim;
	logic [CW-1:0]                 divisor;
	logic signed [COORD_WIDTH-1:0] mean_x, mean_y;
	logic signed [E_W-1:0]         x_e, y_e, dl_e, fd_e, db_e, nb_e, err_x;
	logic signed [SPEED_W-1:0]     fs_s, tr_s;
	logic                          store;
	logic [WAIT_W-1:0]             lost_inc;

	mode_t                         dec_mode;
	logic signed [SPEED_W-1:0]     dec_lin, dec_ang;
	logic signed [COORD_WIDTH-1:0] goal_x_n, goal_y_n;
	logic [WAIT_W-1:0]             lost_n;

	assign ctrl        = ucode(step_q);
	assign frame.ready = ctrl.ready;

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_INPUT:  jump = !frame.valid;
			C_EMPTY:     jump = (count_q == '0);
			C_SCAN_MORE: jump = (ptr_q != IW'(WINDOW_DEPTH - 1));
			C_DIV_MORE:  jump = (div_cnt_q != '0);
			C_OUT_BUSY:  jump = out_valid_q && !result.ready;
			default:     jump = 1'b1;
		endcase
	end

	assign ptr_start = CW'(WINDOW_DEPTH) - count_q;
	assign trim      = count_q >= CW'(3);
	assign divisor   = trim ? (count_q - CW'(2)) : count_q;

	assign x_e   = E_W'(fr_x_q);
	assign y_e   = E_W'(fr_y_q);
	assign dl_e  = E_W'(dl_q);
	assign fd_e  = E_W'(fd_q);
	assign db_e  = E_W'(db_q);
	assign nb_e  = -db_e;
	assign err_x = x_e - fd_e;
	assign fs_s  = SPEED_W'(fs_q);
	assign tr_s  = SPEED_W'(tr_q);
	assign store = fr_seen_q && (x_e < dl_e);

	assign lost_inc = (lost_q < lw_q) ? (lost_q + WAIT_W'(1)) : lost_q;

	tfd_lane #(.COORD_WIDTH(COORD_WIDTH), .WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (ctrl.op),
		.entry   (wx_q[ptr_q]),
		.trim    (trim),
		.divisor (divisor),
		.mean    (mean_x)
	);

	tfd_lane #(.COORD_WIDTH(COORD_WIDTH), .WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (ctrl.op),
		.entry   (wy_q[ptr_q]),
		.trim    (trim),
		.divisor (divisor),
		.mean    (mean_y)
	);

	always_comb begin
		dec_mode = MODE_DRIVE;
		dec_lin  = '0;
		dec_ang  = '0;
		goal_x_n = held_x_q;
		goal_y_n = held_y_q;
		lost_n   = lost_q;
		if (fr_seen_q) begin
			lost_n = '0;
			if (fr_reach_q) begin
				if (err_x > db_e) begin
					dec_lin = fs_s;
				end else if (err_x < nb_e) begin
					dec_lin = -fs_s;
				end
				if (y_e > db_e) begin
					dec_ang = tr_s;
				end else if (y_e < nb_e) begin
					dec_ang = -tr_s;
				end
			end else begin
				dec_mode = MODE_NAV_BLOCKED;
				if (x_e > dl_e) begin
					goal_x_n = mean_x;
					goal_y_n = mean_y;
				end else begin
					goal_x_n = fr_x_q;
					goal_y_n = fr_y_q;
				end
			end
		end else if (have_hist_q) begin
			lost_n = lost_inc;
			if (lost_inc >= lw_q) begin
				dec_mode = MODE_NAV_LOST;
				goal_x_n = mean_x;
				goal_y_n = mean_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_WAIT;
			fd_q        <= RST_FOLLOW_DIST;
			db_q        <= RST_DEAD_BAND;
			dl_q        <= RST_DEPTH_LIMIT;
			lw_q        <= RST_LOST_WAIT;
			fs_q        <= RST_FWD_SPEED;
			tr_q        <= RST_TURN_RATE;
			count_q     <= '0;
			have_hist_q <= 1'b0;
			lost_q      <= '0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= jump ? ctrl.target : step_q + STEP_W'(1);
			if (wr_en) begin
				unique case (wr_index)
					REG_FOLLOW_DIST: fd_q <= wr_data;
					REG_DEAD_BAND:   db_q <= wr_data;
					REG_DEPTH_LIMIT: dl_q <= wr_data;
					REG_LOST_WAIT:   lw_q <= wr_data[WAIT_W-1:0];
					REG_FWD_SPEED:   fs_q <= wr_data;
					REG_TURN_RATE:   tr_q <= wr_data;
					default: ;
				endcase
			end
			if (ctrl.op == OP_UPDATE && store) begin
				have_hist_q <= 1'b1;
				if (count_q < CW'(WINDOW_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.op == OP_DECIDE) begin
				lost_q      <= lost_n;
				held_x_q    <= goal_x_n;
				held_y_q    <= goal_y_n;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LATCH: begin
				if (frame.valid) begin
					fr_seen_q  <= frame.target_seen;
					fr_reach_q <= frame.target_reachable;
					fr_x_q     <= frame.pos_x;
					fr_y_q     <= frame.pos_y;
				end
			end
			OP_UPDATE: begin
				if (store) begin
					for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
						wx_q[i] <= wx_q[i+1];
						wy_q[i] <= wy_q[i+1];
					end
					wx_q[WINDOW_DEPTH-1] <= fr_x_q;
					wy_q[WINDOW_DEPTH-1] <= fr_y_q;
				end
			end
			OP_SCAN_INIT: ptr_q <= ptr_start[IW-1:0];
			OP_SCAN:      ptr_q <= ptr_q + IW'(1);
			OP_NUMER:     div_cnt_q <= DCW'(SUM_W - 1);
			OP_DIVIDE:    div_cnt_q <= div_cnt_q - DCW'(1);
			OP_DECIDE: begin
				out_mode_q <= dec_mode;
				out_lin_q  <= dec_lin;
				out_ang_q  <= dec_ang;
			end
			default: ;
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.mode          = out_mode_q;
	assign result.linear_speed  = out_lin_q;
	assign result.angular_speed = out_ang_q;
	assign result.goal_x        = held_x_q;
	assign result.goal_y        = held_y_q;

endmodule

// ----- design/tfd_checker.sv -----
// Port-level checks for the target follow decision top, bound to it below.
// Depends on tfd_pkg.
module tfd_checker
	import tfd_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [MODE_W-1:0]         mode,
	input logic signed [SPEED_W-1:0] linear_speed,
	input logic signed [SPEED_W-1:0] angular_speed
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mode) && $stable(linear_speed)
			&& $stable(angular_speed))
		else $error("result changed while stalled");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame taken while previous frame in work");

	a_nav_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode != MODE_DRIVE |-> linear_speed == '0 && angular_speed == '0)
		else $error("speed command outside drive mode");

endmodule

bind target_follow_decision_top tfd_checker u_tfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (frame.valid),
	.in_ready      (frame.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.mode          (result.mode),
	.linear_speed  (result.linear_speed),
	.angular_speed (result.angular_speed)
);

// ----- test/tb_top.sv -----
// Testbench for target_follow_decision_top: directed frames, then random bursts under
// several register settings and handshake idling patterns, checked by an in-bench predictor.
// Depends on tfd_pkg, tfd_if and the block under test.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tfd_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int WD = WINDOW_DEPTH_DEF;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 175;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef struct {
		logic   seen;
		logic   reach;
		coord_t x;
		coord_t y;
	} frame_t;

	typedef struct {
		mode_t  mode;
		speed_t lin;
		speed_t ang;
		coord_t gx;
		coord_t gy;
	} decision_t;

	typedef struct {
		bit    seen;
		bit    reach;
		int    x;
		int    y;
		bit    typed;
		mode_t mode;
		int    lin;
		int    ang;
		int    gx;
		int    gy;
	} frame_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	tfd_frame_if  frame_ch ();
	tfd_result_if result_ch ();

	target_follow_decision_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.frame    (frame_ch),
		.result   (result_ch)
	);

	// register copies
	logic [CFG_W-1:0]  follow_dist;
	logic [CFG_W-1:0]  band;
	logic [CFG_W-1:0]  depth_lim;
	logic [WAIT_W-1:0] lost_wait;
	logic [CFG_W-1:0]  fwd_mag;
	logic [CFG_W-1:0]  turn_mag;

	// tracking state
	longint win_x [WD];
	longint win_y [WD];
	int     win_n;
	bit     have_track;
	int     lost_cnt;
	longint avg_x, avg_y;
	longint hold_gx, hold_gy;

	decision_t pending_decisions [$];
	int fails;
	int gap_pct;
	int stall_pct;
	int hold_left;

	frame_row_t frame_rows [22] = '{
		'{0, 0, 0, 0, 1, MODE_DRIVE, 0, 0, 0, 0},
		'{1, 1, 32767, 0, 1, MODE_DRIVE, 115, 0, 0, 0},
		'{1, 1, -32768, -32768, 1, MODE_DRIVE, -115, -38, 0, 0},
		'{1, 1, 256, 77, 1, MODE_DRIVE, 0, 0, 0, 0},
		'{1, 1, 334, -78, 1, MODE_DRIVE, 115, -38, 0, 0},
		'{1, 0, 32767, 32767, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{1, 0, 1792, -5, 1, MODE_NAV_BLOCKED, 0, 0, 1792, -5},
		'{1, 0, 1791, 5, 1, MODE_NAV_BLOCKED, 0, 0, 1791, 5},
		'{1, 1, 0, 32767, 1, MODE_DRIVE, -115, 38, 1791, 5},
		'{0, 1, -1, -1, 1, MODE_DRIVE, 0, 0, 1791, 5},
		'{0, 0, 32767, -32768, 1, MODE_DRIVE, 0, 0, 1791, 5},
		'{0, 1, 12345, 678, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 0, -32768, 32767, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 1, 256, 0, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 1, 5000, -5000, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 0, -300, 300, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 1, 100, 100, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 0, 21845, -21846, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 1, 1, 1, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{1, 1, -1, -1, 0, MODE_DRIVE, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, MODE_DRIVE, 0, 0, 0, 0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint trimmed_avg(input longint w [WD], input int n);
		longint sum, hi, lo, v;
		sum = 0;
		hi = 0;
		lo = 0;
		for (int i = WD - n; i < WD; i++) begin
			v = w[i];
			if (i == WD - n || v > hi) hi = v;
			if (i == WD - n || v < lo) lo = v;
			sum += v;
		end
		if (n >= 3) return (sum - hi - lo) / (n - 2);
		return sum / n;
	endfunction

	function automatic speed_t steer_cmd(input longint err, input longint lim,
			input longint mag);
		if (err > lim) return speed_t'(mag);
		if (-err > lim) return speed_t'(-mag);
		return '0;
	endfunction

	function automatic decision_t decide_frame(input frame_t f);
		decision_t d;
		longint x, y, dl;
		x = f.x;
		y = f.y;
		dl = depth_lim;
		d.mode = MODE_DRIVE;
		d.lin = '0;
		d.ang = '0;
		if (f.seen && x < dl) begin
			for (int i = 0; i < WD - 1; i++) begin
				win_x[i] = win_x[i + 1];
				win_y[i] = win_y[i + 1];
			end
			win_x[WD - 1] = x;
			win_y[WD - 1] = y;
			if (win_n < WD) win_n++;
			have_track = 1'b1;
		end
		if (win_n > 0) begin
			avg_x = trimmed_avg(win_x, win_n);
			avg_y = trimmed_avg(win_y, win_n);
		end
		if (f.seen) begin
			lost_cnt = 0;
			if (f.reach) begin
				d.lin = steer_cmd(x - longint'(follow_dist), band, fwd_mag);
				d.ang = steer_cmd(y, band, turn_mag);
			end else begin
				if (x > dl) begin
					hold_gx = avg_x;
					hold_gy = avg_y;
				end else begin
					hold_gx = x;
					hold_gy = y;
				end
				d.mode = MODE_NAV_BLOCKED;
			end
		end else if (have_track) begin
			if (lost_cnt < int'(lost_wait)) lost_cnt++;
			if (lost_cnt >= int'(lost_wait)) begin
				hold_gx = avg_x;
				hold_gy = avg_y;
				d.mode = MODE_NAV_LOST;
			end
		end
		d.gx = coord_t'(hold_gx);
		d.gy = coord_t'(hold_gy);
		return d;
	endfunction

	function automatic coord_t coord_near(input longint center, input longint spread);
		longint v;
		if ($urandom_range(3) == 0) return coord_t'($urandom);
		v = center + longint'($urandom_range(32'(2 * spread))) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return coord_t'(v);
	endfunction

	task automatic reset_model();
		follow_dist = RST_FOLLOW_DIST;
		band = RST_DEAD_BAND;
		depth_lim = RST_DEPTH_LIMIT;
		lost_wait = RST_LOST_WAIT;
		fwd_mag = RST_FWD_SPEED;
		turn_mag = RST_TURN_RATE;
		for (int i = 0; i < WD; i++) begin
			win_x[i] = 0;
			win_y[i] = 0;
		end
		win_n = 0;
		have_track = 1'b0;
		lost_cnt = 0;
		avg_x = 0;
		avg_y = 0;
		hold_gx = 0;
		hold_gy = 0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fails++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		case (idx)
			REG_FOLLOW_DIST: follow_dist = data;
			REG_DEAD_BAND:   band = data;
			REG_DEPTH_LIMIT: depth_lim = data;
			REG_LOST_WAIT:   lost_wait = data[WAIT_W-1:0];
			REG_FWD_SPEED:   fwd_mag = data;
			REG_TURN_RATE:   turn_mag = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic send_frame(input frame_t f, input bit typed, input decision_t want);
		decision_t d;
		while ($urandom_range(99) < gap_pct) begin
			frame_ch.valid = 1'b0;
			@(negedge clk);
		end
		frame_ch.valid = 1'b1;
		frame_ch.target_seen = f.seen;
		frame_ch.target_reachable = f.reach;
		frame_ch.pos_x = f.x;
		frame_ch.pos_y = f.y;
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
		d = decide_frame(f);
		pending_decisions.push_back(typed ? want : d);
		@(negedge clk);
		frame_ch.valid = 1'b0;
	endtask

	task automatic drain_pipe();
		frame_ch.valid = 1'b0;
		while (pending_decisions.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic apply_setting(input int phase);
		logic [CFG_W-1:0] fd, db, dl, lw, fs, tr;
		case (phase)
			0: begin
				fd = RST_FOLLOW_DIST;
				db = RST_DEAD_BAND;
				dl = RST_DEPTH_LIMIT;
				lw = CFG_W'(RST_LOST_WAIT);
				fs = RST_FWD_SPEED;
				tr = RST_TURN_RATE;
			end
			1: begin
				// wait limit written as 256 is stored as zero (low eight bits only)
				fd = '0;
				db = '0;
				dl = '1;
				lw = 15'd256;
				fs = '1;
				tr = '1;
			end
			2: begin
				fd = '1;
				db = '1;
				dl = '0;
				lw = 15'd255;
				fs = '0;
				tr = '0;
			end
			default: begin
				fd = CFG_W'($urandom_range(1024));
				db = CFG_W'($urandom_range(300));
				dl = ($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(3000, 256));
				lw = CFG_W'($urandom_range(6));
				fs = CFG_W'($urandom);
				tr = CFG_W'($urandom);
			end
		endcase
		write_reg(REG_FOLLOW_DIST, fd);
		write_reg(REG_DEAD_BAND, db);
		write_reg(REG_DEPTH_LIMIT, dl);
		write_reg(REG_LOST_WAIT, lw);
		write_reg(REG_FWD_SPEED, fs);
		write_reg(REG_TURN_RATE, tr);
		write_reg(phase[0] ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
	endtask

	// receiver: random stalls, plus a counted hold-off when requested
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		decision_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_decisions.size() == 0) begin
				fails++;
				$error("decision transfer with none expected");
			end else begin
				want = pending_decisions.pop_front();
				check_field("mode", want.mode, result_ch.mode);
				check_field("linear_speed", want.lin, result_ch.linear_speed);
				check_field("angular_speed", want.ang, result_ch.angular_speed);
				check_field("goal_x", want.gx, result_ch.goal_x);
				check_field("goal_y", want.gy, result_ch.goal_y);
			end
		end
	end

	initial begin
		frame_t f;
		decision_t want;
		int sent, kind, len, lost_len;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.target_seen = 1'b0;
		frame_ch.target_reachable = 1'b0;
		frame_ch.pos_x = '0;
		frame_ch.pos_y = '0;
		fails = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (frame_rows[i]) begin
			f.seen = frame_rows[i].seen;
			f.reach = frame_rows[i].reach;
			f.x = coord_t'(frame_rows[i].x);
			f.y = coord_t'(frame_rows[i].y);
			want.mode = frame_rows[i].mode;
			want.lin = speed_t'(frame_rows[i].lin);
			want.ang = speed_t'(frame_rows[i].ang);
			want.gx = coord_t'(frame_rows[i].gx);
			want.gy = coord_t'(frame_rows[i].gy);
			send_frame(f, frame_rows[i].typed, want);
		end
		drain_pipe();

		for (int phase = 0; phase < PHASES; phase++) begin
			apply_setting(phase);
			case (phase % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 69; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 69; end
				default: begin gap_pct = 11; stall_pct = 11; end
			endcase
			if (phase == 3) begin
				// long receiver hold-off while frames keep coming
				@(posedge clk);
				hold_left = 400;
				@(negedge clk);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(9);
				lost_len = int'(lost_wait) + 2;
				if (lost_len > 16) lost_len = 16;
				if (kind <= 5) len = $urandom_range(8, 1);
				else if (kind <= 8) len = $urandom_range(lost_len, 1);
				else len = 1;
				for (int j = 0; j < len; j++) begin
					if (kind <= 5) begin
						f.seen = 1'b1;
						f.reach = ($urandom_range(2) != 0);
						case ($urandom_range(2))
							0: f.x = coord_near(follow_dist, longint'(band) + 16);
							1: f.x = coord_near(depth_lim, longint'(band) + 16);
							default: f.x = coord_near(0, longint'(band) + 16);
						endcase
						f.y = coord_near(0, longint'(band) + 16);
					end else begin
						f.seen = (kind == 9) ? 1'($urandom) : 1'b0;
						f.reach = 1'($urandom);
						f.x = coord_t'($urandom);
						f.y = coord_t'($urandom);
					end
					send_frame(f, 1'b0, want);
					sent++;
				end
			end
			drain_pipe();
		end

		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
